>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the page allocator.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, muted while reset is high.
`define BPA_ASSERT(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("page allocator check failed");

// Check a property on every rising edge, reset included.
`define BPA_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) (prop)) \
    else $error("page allocator check failed");

`endif

>>> hw/rtl/bpa_pkg.sv
// Types, constants and the free-page search of the bitmap page allocator.
// Used by bitmap_page_allocator_unit; depends on nothing else.
package bpa_pkg;

  localparam int TotalPages    = 48;
  localparam int ReservedPages = 3;
  localparam int PageW         = 6;
  localparam int PageShift     = 8;
  localparam int AddrW         = 16;
  localparam int SizeW         = 16;

  localparam logic [SizeW-1:0] MaxRequest = 16'h00FF;
  localparam logic [AddrW-1:0] LoAddr     = AddrW'(ReservedPages * 256);
  localparam logic [AddrW-1:0] HiAddr     = AddrW'(TotalPages * 256);

  localparam logic [TotalPages-1:0] ReservedMask =
    TotalPages'((64'd1 << ReservedPages) - 64'd1);
  localparam logic [PageW-1:0] FirstPage     = PageW'(ReservedPages);
  localparam logic             ExhaustedInit = (ReservedPages >= TotalPages);

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_MEMORY = 2'd1,
    ST_TOO_LARGE     = 2'd2,
    ST_FREE_IGNORED  = 2'd3
  } status_t;

  typedef struct packed {
    logic             found;
    logic [PageW-1:0] page;
  } search_t;

  // Lowest clear bit at or above the first unreserved page.
  function automatic search_t find_free(input logic [TotalPages-1:0] map);
    search_t res;
    res.found = 1'b0;
    res.page  = '0;
    for (int p = TotalPages - 1; p >= ReservedPages; p--) begin
      if (!map[p]) begin
        res.found = 1'b1;
        res.page  = PageW'(p);
      end
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/bitmap_page_allocator_unit.sv
// Bitmap page allocator: input register, allocate/free logic, result register.
// Depends on bpa_pkg and assert_macros.svh.
//
// Hands out 256-byte pages of a 48-page space, lowest free page first; pages 0 to 2 stay
// reserved. Each accepted word (allocate or free) yields exactly one result word. The word
// is held in the input register, where the bitmap update and the 48-bit find-first-free
// search run, and its result is then held in the result register. The result is offered
// once the word has passed through both registers. A word may be accepted every cycle while
// the output side takes results; stalls on the output side back up through the two registers.
`include "assert_macros.svh"

module bitmap_page_allocator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [bpa_pkg::SizeW-1:0] request_size,
  input  logic [bpa_pkg::AddrW-1:0] release_address,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bpa_pkg::AddrW-1:0] page_address,
  output logic [1:0]                status
);

  // input register
  logic                      s1_valid;
  logic                      s1_action;
  logic [bpa_pkg::SizeW-1:0] s1_size;
  logic [bpa_pkg::AddrW-1:0] s1_addr;

  // allocator state
  logic [bpa_pkg::TotalPages-1:0] used_map, used_map_next;
  logic [bpa_pkg::PageW-1:0]      next_free_page, next_free_page_next;
  logic                           exhausted, exhausted_next;

  logic [bpa_pkg::AddrW-1:0] page_address_next;
  bpa_pkg::status_t          status_next;
  bpa_pkg::search_t          search;
  logic [bpa_pkg::PageW-1:0] rel_page;
  logic                      advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign rel_page = s1_addr[bpa_pkg::PageShift +: bpa_pkg::PageW];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_action <= action;
      s1_size   <= request_size;
      s1_addr   <= release_address;
    end
  end

  always_comb begin
    used_map_next       = used_map;
    next_free_page_next = next_free_page;
    exhausted_next      = exhausted;
    page_address_next   = '0;
    status_next         = bpa_pkg::ST_OK;
    search              = bpa_pkg::find_free(used_map | (bpa_pkg::TotalPages'(1) << next_free_page));
    if (bpa_pkg::action_t'(s1_action) == bpa_pkg::ACT_ALLOC) begin
      if (exhausted) begin
        status_next = bpa_pkg::ST_OUT_OF_MEMORY;
      end else if (s1_size > bpa_pkg::MaxRequest) begin
        status_next = bpa_pkg::ST_TOO_LARGE;
      end else begin
        page_address_next = bpa_pkg::AddrW'({next_free_page, bpa_pkg::PageShift'(0)});
        used_map_next     = used_map | (bpa_pkg::TotalPages'(1) << next_free_page);
        if (search.found) begin
          next_free_page_next = search.page;
        end else begin
          exhausted_next = 1'b1;
        end
      end
    end else begin
      if (s1_addr < bpa_pkg::LoAddr || s1_addr >= bpa_pkg::HiAddr) begin
        status_next = bpa_pkg::ST_FREE_IGNORED;
      end else begin
        used_map_next = used_map & ~(bpa_pkg::TotalPages'(1) << rel_page);
        // a freed page below the pointer, or any page once full, becomes the next one
        if (exhausted || rel_page < next_free_page) begin
          next_free_page_next = rel_page;
          exhausted_next      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map       <= bpa_pkg::ReservedMask;
      next_free_page <= bpa_pkg::FirstPage;
      exhausted      <= bpa_pkg::ExhaustedInit;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        used_map       <= used_map_next;
        next_free_page <= next_free_page_next;
        exhausted      <= exhausted_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      page_address <= page_address_next;
      status       <= status_next;
    end
  end

  `BPA_ASSERT(a_reserved_held, clk, rst, (used_map & bpa_pkg::ReservedMask) == bpa_pkg::ReservedMask)
  `BPA_ASSERT(a_next_is_free, clk, rst, !exhausted |-> !used_map[next_free_page])
  `BPA_ASSERT(a_full_when_exhausted, clk, rst, exhausted |-> (&used_map))
  `BPA_ASSERT(a_next_above_reserved, clk, rst, next_free_page >= bpa_pkg::FirstPage)

endmodule

>>> tb/bitmap_page_allocator_unit_test.sv
// Self-checking testbench for bitmap_page_allocator_unit: allocate and free words against a
// bitmap predictor, with random stalls on both sides. Depends on bpa_pkg and the unit's RTL.
`timescale 1ns / 1ps

module bitmap_page_allocator_unit_test;

  localparam int CycleLimit = 200000;

  typedef struct packed {
    bpa_pkg::action_t          act;
    logic [bpa_pkg::SizeW-1:0] size;
    logic [bpa_pkg::AddrW-1:0] addr;
  } page_request_t;

  typedef struct packed {
    logic [bpa_pkg::AddrW-1:0] page;
    bpa_pkg::status_t          st;
  } page_reply_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      action = 1'b0;
  logic [bpa_pkg::SizeW-1:0] request_size = '0;
  logic [bpa_pkg::AddrW-1:0] release_address = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [bpa_pkg::AddrW-1:0] page_address;
  logic [1:0]                status;

  page_request_t request_queue[$];
  page_reply_t   expected_replies[$];
  page_request_t offered;

  // Predictor state: pages in use, lowest free page, and the no-page-left flag.
  logic [bpa_pkg::TotalPages-1:0] used_pages;
  logic [bpa_pkg::PageW-1:0]      lowest_free;
  logic                           pages_exhausted;

  int cycle_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int fail_count = 0;

  bitmap_page_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .request_size(request_size),
    .release_address(release_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .page_address(page_address),
    .status(status)
  );

  always #10 clk = ~clk;

  function automatic page_reply_t allocate_or_release(page_request_t r);
    page_reply_t               rep;
    logic [bpa_pkg::PageW-1:0] pg;
    logic                      found;
    rep.page = '0;
    rep.st   = bpa_pkg::ST_OK;
    if (r.act == bpa_pkg::ACT_ALLOC) begin
      if (pages_exhausted) begin
        rep.st = bpa_pkg::ST_OUT_OF_MEMORY;
      end else if (r.size > bpa_pkg::MaxRequest) begin
        rep.st = bpa_pkg::ST_TOO_LARGE;
      end else begin
        rep.page = bpa_pkg::AddrW'(lowest_free) << bpa_pkg::PageShift;
        used_pages[lowest_free] = 1'b1;
        found = 1'b0;
        // scan upwards; keep the old pointer when nothing is left
        for (int p = bpa_pkg::ReservedPages; p < bpa_pkg::TotalPages; p++) begin
          if (!found && !used_pages[p]) begin
            found       = 1'b1;
            lowest_free = bpa_pkg::PageW'(p);
          end
        end
        pages_exhausted = !found;
      end
    end else begin
      if (r.addr < bpa_pkg::LoAddr || r.addr >= bpa_pkg::HiAddr) begin
        rep.st = bpa_pkg::ST_FREE_IGNORED;
      end else begin
        pg = bpa_pkg::PageW'(r.addr >> bpa_pkg::PageShift);
        used_pages[pg] = 1'b0;
        if (pages_exhausted || pg < lowest_free) begin
          lowest_free     = pg;
          pages_exhausted = 1'b0;
        end
      end
    end
    return rep;
  endfunction

  function automatic page_request_t random_request(int alloc_pct);
    page_request_t r;
    int            pick;
    r.act  = ($urandom_range(99) < alloc_pct) ? bpa_pkg::ACT_ALLOC : bpa_pkg::ACT_FREE;
    pick   = $urandom_range(99);
    if (pick < 85) r.size = bpa_pkg::SizeW'($urandom_range(255));
    else if (pick < 90) r.size = bpa_pkg::MaxRequest + 1'b1;
    else r.size = bpa_pkg::SizeW'($urandom);
    pick = $urandom_range(99);
    if (pick < 80) begin
      r.addr = bpa_pkg::AddrW'($urandom_range(int'(bpa_pkg::HiAddr) - 1,
                                              int'(bpa_pkg::LoAddr)));
    end else if (pick < 85) begin
      case ($urandom_range(3))
        0: r.addr = bpa_pkg::LoAddr - 1'b1;
        1: r.addr = bpa_pkg::LoAddr;
        2: r.addr = bpa_pkg::HiAddr - 1'b1;
        default: r.addr = bpa_pkg::HiAddr;
      endcase
    end else begin
      r.addr = bpa_pkg::AddrW'($urandom);
    end
    return r;
  endfunction

  function automatic page_request_t make_request(bpa_pkg::action_t act, int size, int addr);
    page_request_t r;
    r.act  = act;
    r.size = bpa_pkg::SizeW'(size);
    r.addr = bpa_pkg::AddrW'(addr);
    return r;
  endfunction

  // Hold back idling on both sides for a stretch in the middle of the run.
  function automatic logic busy_stretch(int n);
    return n >= 400 && n < 650;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Driver: hold the word until taken, then offer the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_replies.push_back(allocate_or_release(offered));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 &&
            (busy_stretch(accepted_count) || $urandom_range(99) >= 19)) begin
          offered = request_queue.pop_front();
          in_valid        <= 1'b1;
          action          <= offered.act;
          request_size    <= offered.size;
          release_address <= offered.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin
    page_reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result word: page_address %h status %0d", page_address, status);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (page_address !== want.page) begin
            $error("page_address expected %h actual %h", want.page, page_address);
            fail_count++;
          end
          if (status !== want.st) begin
            $error("status expected %0d actual %0d", want.st, status);
            fail_count++;
          end
        end
        checked_count++;
      end
      out_ready <= busy_stretch(checked_count) || ($urandom_range(99) >= 19);
    end
  end

  initial begin
    used_pages      = bpa_pkg::ReservedMask;
    lowest_free     = bpa_pkg::FirstPage;
    pages_exhausted = bpa_pkg::ExhaustedInit;

    // directed: size and address edges, unaligned and repeated frees
    request_queue.push_back(make_request(bpa_pkg::ACT_ALLOC, 0, 16'hFFFF));
    request_queue.push_back(make_request(bpa_pkg::ACT_ALLOC, 255, 0));
    request_queue.push_back(make_request(bpa_pkg::ACT_ALLOC, 256, 0));
    request_queue.push_back(make_request(bpa_pkg::ACT_ALLOC, 16'hFFFF, 0));
    request_queue.push_back(make_request(bpa_pkg::ACT_ALLOC, 16'h8000, 16'h5555));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 16'hFFFF, 16'h0000));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 0, 16'h02FF));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 0, 16'h3000));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 0, 16'hFFFF));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 0, 16'h0301));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 0, 16'h0300));
    request_queue.push_back(make_request(bpa_pkg::ACT_ALLOC, 16'h0080, 0));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 0, 16'h2FFF));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 0, 16'h04AB));
    request_queue.push_back(make_request(bpa_pkg::ACT_ALLOC, 16'h00FF, 0));
    request_queue.push_back(make_request(bpa_pkg::ACT_ALLOC, 1, 0));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 16'hAAAA, 16'h1234));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 0, 16'hEDCB));
    request_queue.push_back(make_request(bpa_pkg::ACT_FREE, 0, 16'h8000));

    // random: alternate filling runs, which reach exhaustion, with draining runs
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 135; i++) begin
        request_queue.push_back(random_request(ph % 2 == 0 ? 85 : 30));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sample between edges so the driver and monitor have settled
    while (request_queue.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
